// File: hdl/rsf_pkg.sv
// Shared types, constants and helpers for the replicator softmax unit.
`timescale 1ns / 1ps
`default_nettype none
package rsf_pkg;

	localparam int DATA_W  = 16;
	localparam int STEP_W  = 12;
	localparam int N_LOGIT = 3;
	localparam int CADDR_W = 2;

	// configuration register indexes
	localparam logic [CADDR_W-1:0] REG_RATE_GAIN    = 2'd0;
	localparam logic [CADDR_W-1:0] REG_TIME_STEP    = 2'd1;
	localparam logic [CADDR_W-1:0] REG_STEP_COUNT   = 2'd2;
	localparam logic [CADDR_W-1:0] REG_START_WEIGHT = 2'd3;

	// register reset values
	localparam logic [DATA_W-1:0] RST_RATE_GAIN    = 16'd8192;
	localparam logic [DATA_W-1:0] RST_TIME_STEP    = 16'd81;
	localparam logic [STEP_W-1:0] RST_STEP_COUNT   = 12'd100;
	localparam logic [DATA_W-1:0] RST_START_WEIGHT = 16'd819;

	typedef logic [1:0] idx_t;
	typedef logic [1:0] stg_t;

	localparam idx_t IDX_LAST = 2'd2;

	// multiplier pass stages of one weight update
	localparam stg_t STG_DIFF = 2'd0;  // z * (logit - sum)
	localparam stg_t STG_GAIN = 2'd1;  // rate_gain * previous
	localparam stg_t STG_STEP = 2'd2;  // previous * time_step

	typedef struct packed {
		logic load;
		logic mul;
		stg_t stage;
		idx_t idx;
		logic upd;
		logic div_init;
		logic div_step;
		logic div_save;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic zero_sum;
	} stat_t;

	// magnitude of a 16-bit two's complement value, -32768 maps to 32768
	function automatic logic [DATA_W-1:0] abs16(input logic [DATA_W-1:0] a);
		abs16 = a[DATA_W-1] ? (~a + 16'd1) : a;
	endfunction

endpackage
`default_nettype wire

// File: hdl/rsf_ctrl.sv
// Controller state machine sequencing update passes and divisions.
`timescale 1ns / 1ps
`default_nettype none
module rsf_ctrl #(
	parameter int FRAC_BITS = 13
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	output logic                         out_valid,
	input  wire                          out_ready,
	input  wire  [rsf_pkg::STEP_W-1:0]   step_count,
	input  rsf_pkg::stat_t               stat,
	output rsf_pkg::cmd_t                cmd
);
	import rsf_pkg::*;

	localparam int MAG_W = DATA_W + FRAC_BITS;
	localparam int CNT_W = $clog2(MAG_W);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_DIVI = 3'd3;
	localparam logic [2:0] ST_DIVS = 3'd4;
	localparam logic [2:0] ST_DIVW = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]       state_q;
	logic [STEP_W-1:0] pass_q;
	stg_t             stage_q;
	idx_t             idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd          = '0;
		cmd.stage    = stage_q;
		cmd.idx      = idx_q;
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.mul      = (state_q == ST_MUL);
		cmd.upd      = (state_q == ST_UPD);
		cmd.div_init = (state_q == ST_DIVI) && !stat.zero_sum;
		cmd.div_step = (state_q == ST_DIVS);
		cmd.div_save = (state_q == ST_DIVW);
		cmd.out_load = (state_q == ST_OUT) && out_free;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= '0;
			stage_q <= STG_DIFF;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pass_q  <= '0;
						stage_q <= STG_DIFF;
						idx_q   <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (idx_q == IDX_LAST) begin
						idx_q <= '0;
						if (stage_q == STG_STEP) begin
							state_q <= ST_UPD;
						end else begin
							stage_q <= stage_q + 2'd1;
						end
					end else begin
						idx_q <= idx_q + 2'd1;
					end
				end
				ST_UPD: begin
					stage_q <= STG_DIFF;
					idx_q   <= '0;
					if (pass_q == step_count) begin
						state_q <= ST_DIVI;
					end else begin
						pass_q  <= pass_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_DIVI: begin
					cnt_q <= '0;
					if (stat.zero_sum) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DIVS;
					end
				end
				ST_DIVS: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(MAG_W - 1)) begin
						state_q <= ST_DIVW;
					end
				end
				ST_DIVW: begin
					if (idx_q == IDX_LAST) begin
						state_q <= ST_OUT;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= ST_DIVI;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// File: hdl/rsf_dp.sv
// Datapath: weights, shared multiplier, serial divider and output word register.
`timescale 1ns / 1ps
`default_nettype none
module rsf_dp #(
	parameter int FRAC_BITS = 13
) (
	input  wire                          clk,
	input  rsf_pkg::cmd_t                cmd,
	output rsf_pkg::stat_t               stat,
	input  wire  [3*rsf_pkg::DATA_W-1:0] logits,
	input  wire  [rsf_pkg::DATA_W-1:0]   rate_gain,
	input  wire  [rsf_pkg::DATA_W-1:0]   time_step,
	input  wire  [rsf_pkg::DATA_W-1:0]   start_weight,
	output logic [3*rsf_pkg::DATA_W-1:0] out_probs,
	output logic                         out_zero
);
	import rsf_pkg::*;

	localparam int MAG_W  = DATA_W + FRAC_BITS;
	localparam int PROD_W = 2 * DATA_W;

	logic [DATA_W-1:0] logit_q [N_LOGIT];
	logic [DATA_W-1:0] z_q     [N_LOGIT];
	logic [DATA_W-1:0] m_q     [N_LOGIT];
	logic [DATA_W-1:0] q_q     [N_LOGIT];
	logic [DATA_W-1:0] out_q   [N_LOGIT];
	logic [DATA_W-1:0] sum_q;
	logic              zero_q;

	logic [DATA_W-1:0] diff;
	logic [DATA_W-1:0] op_a;
	logic [DATA_W-1:0] op_b;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] prod_sh;
	logic [DATA_W-1:0] z_new   [N_LOGIT];

	logic [DATA_W-1:0] rem_q;
	logic [MAG_W-1:0]  quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic              neg_q;
	logic [DATA_W:0]   trial;
	logic [DATA_W+1:0] tdiff;
	logic              ge;

	assign stat.zero_sum = (sum_q == '0);

	// shared multiplier operand select
	assign diff = logit_q[cmd.idx] - sum_q;
	always_comb begin
		case (cmd.stage)
			STG_DIFF: begin
				op_a = z_q[cmd.idx];
				op_b = diff;
			end
			STG_GAIN: begin
				op_a = rate_gain;
				op_b = m_q[cmd.idx];
			end
			STG_STEP: begin
				op_a = m_q[cmd.idx];
				op_b = time_step;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// s2.13 product, floor shift, wrap to 16 bits
	assign prod    = PROD_W'($signed(op_a) * $signed(op_b));
	assign prod_sh = PROD_W'($signed(prod) >>> FRAC_BITS);

	always_comb begin
		for (int i = 0; i < N_LOGIT; i++) begin
			z_new[i] = z_q[i] + m_q[i];
		end
	end

	// weights, products and running sum
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < N_LOGIT; i++) begin
				logit_q[i] <= logits[i*DATA_W +: DATA_W];
				z_q[i]     <= start_weight;
			end
			sum_q <= start_weight + start_weight + start_weight;
		end
		if (cmd.mul) begin
			m_q[cmd.idx] <= prod_sh[DATA_W-1:0];
		end
		if (cmd.upd) begin
			for (int i = 0; i < N_LOGIT; i++) begin
				z_q[i] <= z_new[i];
			end
			sum_q <= z_new[0] + z_new[1] + z_new[2];
		end
	end

	// restoring divider, one quotient bit per cycle
	assign trial = {rem_q, quo_q[MAG_W-1]};
	assign tdiff = {1'b0, trial} - {2'b00, dvs_q};
	assign ge    = !tdiff[DATA_W+1];

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= '0;
			quo_q <= {abs16(z_q[cmd.idx]), {FRAC_BITS{1'b0}}};
			dvs_q <= abs16(sum_q);
			neg_q <= z_q[cmd.idx][DATA_W-1] ^ sum_q[DATA_W-1];
		end else if (cmd.div_step) begin
			rem_q <= ge ? tdiff[DATA_W-1:0] : trial[DATA_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], ge};
		end
		if (cmd.div_save) begin
			q_q[cmd.idx] <= neg_q ? (~quo_q[DATA_W-1:0] + 16'd1) : quo_q[DATA_W-1:0];
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			for (int i = 0; i < N_LOGIT; i++) begin
				out_q[i] <= stat.zero_sum ? '0 : q_q[i];
			end
			zero_q <= stat.zero_sum;
		end
	end

	assign out_probs = {out_q[2], out_q[1], out_q[0]};
	assign out_zero  = zero_q;

endmodule
`default_nettype wire

// File: hdl/replicator_softmax_fixed_unit.sv
// Top level: configuration registers, controller and datapath of the softmax unit.
// A zero final sum skips the divider. The unit accepts no new word until the last one
// has reached the output register; each pass uses the single shared multiplier nine
// times and then updates the weights, and each quotient takes one bit per cycle.
// Reset (arst_n low, asynchronous) idles the sequencer, drops the output valid and loads
// register defaults; the next word may enter while a finished result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module replicator_softmax_fixed_unit #(
	parameter int FRAC_BITS = 13
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire  [47:0]                    s_axis_tdata,   // logit_0, logit_1, logit_2
	output logic                           m_axis_tvalid,
	input  wire                            m_axis_tready,
	output logic [47:0]                    m_axis_tdata,   // prob_0, prob_1, prob_2
	output logic                           m_axis_tuser,   // zero_sum
	input  wire                            cfg_we,
	input  wire  [rsf_pkg::CADDR_W-1:0]    cfg_addr,
	input  wire  [rsf_pkg::DATA_W-1:0]     cfg_wdata
);
	import rsf_pkg::*;

	logic [DATA_W-1:0] rate_gain_q;
	logic [DATA_W-1:0] time_step_q;
	logic [STEP_W-1:0] step_count_q;
	logic [DATA_W-1:0] start_weight_q;

	cmd_t  cmd;
	stat_t stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_gain_q    <= RST_RATE_GAIN;
			time_step_q    <= RST_TIME_STEP;
			step_count_q   <= RST_STEP_COUNT;
			start_weight_q <= RST_START_WEIGHT;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_RATE_GAIN:    rate_gain_q    <= cfg_wdata;
				REG_TIME_STEP:    time_step_q    <= cfg_wdata;
				REG_STEP_COUNT:   step_count_q   <= cfg_wdata[STEP_W-1:0];
				REG_START_WEIGHT: start_weight_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	rsf_ctrl #(
		.FRAC_BITS(FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.step_count(step_count_q),
		.stat      (stat),
		.cmd       (cmd)
	);

	rsf_dp #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.stat        (stat),
		.logits      (s_axis_tdata),
		.rate_gain   (rate_gain_q),
		.time_step   (time_step_q),
		.start_weight(start_weight_q),
		.out_probs   (m_axis_tdata),
		.out_zero    (m_axis_tuser)
	);

endmodule
`default_nettype wire

// File: tb/sv/replicator_softmax_fixed_checker.sv
// Scoreboard for the replicator softmax unit: predicts every output word and compares it.
`timescale 1ns / 1ps
module replicator_softmax_fixed_checker #(
	parameter int FRAC_BITS = 13
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         s_axis_tvalid,
	input  wire                         s_axis_tready,
	input  wire  [47:0]                 s_axis_tdata,   // logit_0, logit_1, logit_2
	input  wire                         m_axis_tvalid,
	input  wire                         m_axis_tready,
	input  wire  [47:0]                 m_axis_tdata,   // prob_0, prob_1, prob_2
	input  wire                         m_axis_tuser,   // zero_sum
	input  wire                         cfg_we,
	input  wire  [rsf_pkg::CADDR_W-1:0] cfg_addr,
	input  wire  [rsf_pkg::DATA_W-1:0]  cfg_wdata,
	output int                          pending,
	output int                          fail_count
);
	import rsf_pkg::*;

	typedef logic signed [DATA_W-1:0] fx_t;

	typedef struct packed {
		logic [2:0][DATA_W-1:0] prob;
		logic                   zero_sum;
	} probs_t;

	// shadow copy of the configuration registers
	fx_t              gain;
	fx_t              dt;
	logic [STEP_W-1:0] n_steps;
	fx_t              w_start;

	probs_t probs_due[$];
	int     fails = 0;
	int     due_cnt = 0;

	assign fail_count = fails;
	assign pending    = due_cnt;

	// s2.13 multiply: floor shift, keep the low 16 bits
	function automatic fx_t fx_mul(input fx_t a, input fx_t b);
		logic signed [31:0] p;
		logic signed [31:0] q;
		p = a * b;
		q = p >>> FRAC_BITS;
		return q[DATA_W-1:0];
	endfunction

	function automatic fx_t sum3(input fx_t a, input fx_t b, input fx_t c);
		logic signed [DATA_W+1:0] s;
		s = a + b + c;
		return s[DATA_W-1:0];
	endfunction

	// replicator iterations followed by normalization
	function automatic probs_t replicator_softmax(input fx_t l0, input fx_t l1, input fx_t l2);
		fx_t    logit [3];
		fx_t    z [3];
		fx_t    dz [3];
		fx_t    s;
		fx_t    diff;
		longint num;
		longint quo;
		int     t;
		int     i;
		probs_t r;
		logit[0] = l0;
		logit[1] = l1;
		logit[2] = l2;
		for (i = 0; i < 3; i++)
			z[i] = w_start;
		for (t = 0; t <= int'(n_steps); t++) begin
			s = sum3(z[0], z[1], z[2]);
			for (i = 0; i < 3; i++) begin
				diff  = logit[i] - s;
				dz[i] = fx_mul(gain, fx_mul(z[i], diff));
			end
			for (i = 0; i < 3; i++)
				z[i] = z[i] + fx_mul(dz[i], dt);
		end
		s = sum3(z[0], z[1], z[2]);
		r = '0;
		if (s == 0) begin
			r.zero_sum = 1'b1;
		end else begin
			for (i = 0; i < 3; i++) begin
				num = z[i];
				num = num * (longint'(1) << FRAC_BITS);
				quo = num / longint'(s);
				r.prob[i] = quo[DATA_W-1:0];
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fails++;
		end
	endtask

	// register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain    <= RST_RATE_GAIN;
			dt      <= RST_TIME_STEP;
			n_steps <= RST_STEP_COUNT;
			w_start <= RST_START_WEIGHT;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_RATE_GAIN:    gain    <= cfg_wdata;
				REG_TIME_STEP:    dt      <= cfg_wdata;
				REG_STEP_COUNT:   n_steps <= cfg_wdata[STEP_W-1:0];
				REG_START_WEIGHT: w_start <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// predict on each input word, compare each output word
	always @(posedge clk) begin
		probs_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				probs_due.push_back(replicator_softmax(s_axis_tdata[15:0],
					s_axis_tdata[31:16], s_axis_tdata[47:32]));
			if (m_axis_tvalid && m_axis_tready) begin
				if (probs_due.size() == 0) begin
					$error("unexpected output word: tdata=%h tuser=%b", m_axis_tdata,
						m_axis_tuser);
					fails++;
				end else begin
					want = probs_due.pop_front();
					check_field("prob_0", int'($signed(want.prob[0])),
						int'($signed(m_axis_tdata[15:0])));
					check_field("prob_1", int'($signed(want.prob[1])),
						int'($signed(m_axis_tdata[31:16])));
					check_field("prob_2", int'($signed(want.prob[2])),
						int'($signed(m_axis_tdata[47:32])));
					check_field("zero_sum", int'(want.zero_sum), int'(m_axis_tuser));
				end
			end
			due_cnt <= probs_due.size();
		end
	end

endmodule

// File: tb/sv/replicator_softmax_fixed_unit_tb.sv
// Testbench top for the replicator softmax unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module replicator_softmax_fixed_unit_tb;
	import rsf_pkg::*;

	localparam int FRAC_BITS = 13;
	localparam int N_PHASES  = 10;
	localparam int PHASE_LEN = 56;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [47:0]         s_axis_tdata;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [47:0]         m_axis_tdata;
	logic                m_axis_tuser;
	logic                cfg_we;
	logic [CADDR_W-1:0]  cfg_addr;
	logic [DATA_W-1:0]   cfg_wdata;
	int                  pending;
	int                  fail_count;
	logic                idle_on;
	int                  last_steps;

	replicator_softmax_fixed_unit #(.FRAC_BITS(FRAC_BITS)) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	replicator_softmax_fixed_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.pending       (pending),
		.fail_count    (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop
	initial begin
		#30_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// output side: random stall bursts while idling is on
	initial begin
		int hold;
		hold = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				m_axis_tready = 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 19) - 1;
				m_axis_tready = 1'b0;
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	// one input word, with an optional gap in front; returns at a falling edge
	task automatic send_logits(input logic [15:0] l0, input logic [15:0] l1,
			input logic [15:0] l2);
		int gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  = {l2, l1, l0};
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CADDR_W-1:0] idx, input logic [DATA_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_addr  = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// stop sending and wait for every predicted word to come out
	task automatic drain_results();
		s_axis_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_logit();
		logic [31:0] r;
		case ($urandom_range(0, 7))
			0: r = 32'h8000;
			1: r = 32'h7FFF;
			2: r = 32'h0000;
			3, 4, 5: r = $urandom_range(0, 16384) - 8192;
			default: r = $urandom;
		endcase
		return r[15:0];
	endfunction

	function automatic logic [15:0] pick_reg16();
		logic [31:0] r;
		case ($urandom_range(0, 7))
			0: r = 32'h8000;
			1: r = 32'h7FFF;
			2: r = 32'h0000;
			3, 4: r = $urandom_range(0, 16384);
			5: r = $urandom_range(0, 1024) - 512;
			default: r = $urandom;
		endcase
		return r[15:0];
	endfunction

	initial begin
		int          ph;
		int          k;
		int          sc;
		logic [31:0] r;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_addr      = REG_RATE_GAIN;
		cfg_wdata     = '0;
		idle_on       = 1'b1;
		last_steps    = 100;
		arst_n        = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: field extremes and bit patterns
		send_logits(16'h0000, 16'h0000, 16'h0000);
		send_logits(16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_logits(16'h8000, 16'h8000, 16'h8000);
		send_logits(16'h7FFF, 16'h8000, 16'h0000);
		send_logits(16'h8000, 16'h0000, 16'h7FFF);
		send_logits(16'h2000, 16'h0000, 16'hE000);
		send_logits(16'h5555, 16'hAAAA, 16'h5555);
		send_logits(16'hAAAA, 16'h5555, 16'hAAAA);
		send_logits(16'h0001, 16'hFFFF, 16'h0000);
		send_logits(16'h1000, 16'h0800, 16'h0400);
		drain_results();

		// zero start weight: weights stay zero, zero-sum flag
		write_reg(REG_START_WEIGHT, 16'h0000);
		write_reg(REG_STEP_COUNT, 16'h0003);
		send_logits(16'h2000, 16'h0000, 16'hE000);
		send_logits(16'h7FFF, 16'h8000, 16'h0000);
		drain_results();

		// single pass with extreme gains
		write_reg(REG_RATE_GAIN, 16'h8000);
		write_reg(REG_TIME_STEP, 16'h7FFF);
		write_reg(REG_START_WEIGHT, 16'h7FFF);
		write_reg(REG_STEP_COUNT, 16'h0000);
		send_logits(16'h7FFF, 16'h8000, 16'h0000);
		send_logits(16'h0000, 16'h0000, 16'h0000);
		send_logits(16'h8000, 16'h8000, 16'h8000);
		drain_results();

		// longest loop; upper write bits of the count are ignored
		write_reg(REG_RATE_GAIN, 16'h7FFF);
		write_reg(REG_TIME_STEP, 16'h8000);
		write_reg(REG_START_WEIGHT, 16'h8000);
		write_reg(REG_STEP_COUNT, 16'hFFFF);
		send_logits(16'h1234, 16'hEDCB, 16'h0100);
		send_logits(16'h7FFF, 16'h0000, 16'h8000);
		drain_results();

		// random phases, each with its own register setting
		for (ph = 0; ph < N_PHASES; ph++) begin
			idle_on = !(ph == 4 || ph == N_PHASES - 1);
			case ($urandom_range(0, 7))
				0: sc = 0;
				1: sc = 100;
				default: sc = $urandom_range(1, 12);
			endcase
			last_steps = sc;
			r = $urandom;
			write_reg(REG_RATE_GAIN, pick_reg16());
			write_reg(REG_TIME_STEP, pick_reg16());
			write_reg(REG_STEP_COUNT, {r[15:12], sc[11:0]});
			write_reg(REG_START_WEIGHT, pick_reg16());
			for (k = 0; k < PHASE_LEN; k++)
				send_logits(pick_logit(), pick_logit(), pick_logit());
			drain_results();
		end

		repeat (10 * (last_steps + 1) + 200) @(negedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: filelist.f
hdl/rsf_pkg.sv
hdl/rsf_ctrl.sv
hdl/rsf_dp.sv
hdl/replicator_softmax_fixed_unit.sv
tb/sv/replicator_softmax_fixed_checker.sv
tb/sv/replicator_softmax_fixed_unit_tb.sv
